>>> rtl/mrts_pkg.sv
// Shared types and constants for the round timer sequencer.
`default_nettype none
package mrts_pkg;
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_LOAD    = 3'd1;
  localparam logic [2:0] MODE_START   = 3'd2;
  localparam logic [2:0] MODE_CONFIRM = 3'd3;
  localparam logic [2:0] MODE_ABORT   = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_STARTED = 2'd1;
  localparam logic [1:0] EV_EXPIRED = 2'd2;
  localparam logic [1:0] EV_FINISH  = 2'd3;

  localparam int TOTAL_W = 40;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // controller -> datapath commands
  typedef struct packed {
    logic apply;      // register decoded item effect
    logic tbl_rd;     // read table into rd_q
    logic rd_cur;     // 1: current step, 0: walk index
    logic div_start;  // start divide of the entry in rd_q
    logic dur_ld;     // divider result becomes current duration
    logic round_go;   // pending round start picks run or wait
    logic mul_start;  // multiply quotient by rounds
    logic mul_cur;    // 1: rounds left in current step, 0: all rounds
    logic acc_clr;
    logic acc_init;   // acc = remaining + product
    logic acc_add;    // acc += product, saturating
    logic walk_init;
    logic walk_inc;
  } mrts_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_end;
    logic need_total;
  } mrts_sts_t;
endpackage
`default_nettype wire

>>> rtl/mrts_div.sv
// Radix-2 restoring divider for duration / speed factor, one bit per cycle.
`default_nettype none
module mrts_div import mrts_pkg::*; #(
  parameter int NW = 24,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   rem;
  logic [NW-1:0] q;
  logic [DW:0]   trial;
  logic [DW-1:0] dv;

  assign trial = {rem[DW-1:0], q[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        q    <= num;
        dv   <= (den == '0) ? DW'(1) : den;
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule
`default_nettype wire

>>> rtl/mrts_ctrl.sv
// Sequencing state machine: decode, duration divide, total-left walk.
`default_nettype none
module mrts_ctrl import mrts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  mrts_sts_t sts,
  output mrts_cmd_t cmd,
  output logic      in_rdy,
  output logic      out_vld
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;   // read current entry
  localparam logic [3:0] S_CDIV  = 4'd2;   // divide current entry
  localparam logic [3:0] S_CWAIT = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_NRD   = 4'd5;   // read entry of the new current step
  localparam logic [3:0] S_NDIV  = 4'd6;
  localparam logic [3:0] S_NWAIT = 4'd7;
  localparam logic [3:0] S_TSEL  = 4'd8;   // total needed or not
  localparam logic [3:0] S_TINIT = 4'd9;
  localparam logic [3:0] S_WCHK  = 4'd10;
  localparam logic [3:0] S_TDIV  = 4'd11;
  localparam logic [3:0] S_TWAIT = 4'd12;
  localparam logic [3:0] S_TMUL  = 4'd13;
  localparam logic [3:0] S_TADD  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_CRD;
      S_CRD: begin
        cmd.tbl_rd = 1'b1; cmd.rd_cur = 1'b1; state_next = S_CDIV;
      end
      S_CDIV:  begin cmd.div_start = 1'b1; state_next = S_CWAIT; end
      S_CWAIT: if (sts.div_done) begin
        cmd.dur_ld = 1'b1; state_next = S_APPLY;
      end
      S_APPLY: begin cmd.apply = 1'b1; state_next = S_NRD; end
      S_NRD: begin
        cmd.tbl_rd = 1'b1; cmd.rd_cur = 1'b1; state_next = S_NDIV;
      end
      S_NDIV:  begin cmd.div_start = 1'b1; state_next = S_NWAIT; end
      S_NWAIT: if (sts.div_done) begin
        cmd.dur_ld = 1'b1; cmd.round_go = 1'b1; state_next = S_TSEL;
      end
      S_TSEL: begin
        if (sts.need_total) begin
          cmd.mul_start = 1'b1; cmd.mul_cur = 1'b1; cmd.walk_init = 1'b1;
          state_next = S_TINIT;
        end else begin
          cmd.acc_clr = 1'b1; state_next = S_OUT;
        end
      end
      S_TINIT: begin cmd.acc_init = 1'b1; state_next = S_WCHK; end
      S_WCHK: begin
        if (sts.walk_end) state_next = S_OUT;
        else begin
          cmd.tbl_rd = 1'b1; state_next = S_TDIV;
        end
      end
      S_TDIV:  begin cmd.div_start = 1'b1; state_next = S_TWAIT; end
      S_TWAIT: if (sts.div_done) state_next = S_TMUL;
      S_TMUL:  begin cmd.mul_start = 1'b1; state_next = S_TADD; end
      S_TADD: begin
        cmd.acc_add = 1'b1; cmd.walk_inc = 1'b1; state_next = S_WCHK;
      end
      S_OUT:   if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_rdy  = (state == S_IDLE);
  assign out_vld = (state == S_OUT);
endmodule
`default_nettype wire

>>> rtl/mrts_dp.sv
// Datapath: step table, sequencer registers, divider, multiply and total sum.
`default_nettype none
module mrts_dp import mrts_pkg::*; #(
  parameter int MAX_STEPS    = 64,
  parameter int SECONDS_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_fire,
  input  wire logic [2:0]  mode,
  input  wire logic [5:0]  entry_index,
  input  wire logic [23:0] entry_seconds,
  input  wire logic [7:0]  entry_rounds,
  input  wire logic        entry_open,
  input  wire logic [6:0]  step_count,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  mrts_cmd_t        cmd,
  output mrts_sts_t        sts,
  output logic [1:0]       phase,
  output logic [6:0]       step_now,
  output logic [7:0]       round_now,
  output logic [1:0]       event_code,
  output logic             rejected,
  output logic [23:0]      remaining_seconds,
  output logic             remaining_valid,
  output logic [39:0]      total_left_seconds
);
  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SW = SECONDS_BITS;
  localparam int EW = SW + 9;
  localparam int PW = SW + 9;

  logic [EW-1:0] mem [MAX_STEPS];
  logic [EW-1:0] rd_q;
  logic [15:0]   speed;
  logic [2:0]    mode_q;
  logic [5:0]    idx_q;
  logic [SW-1:0] secs_q;
  logic [7:0]    rnds_q;
  logic          opn_q;
  logic [6:0]    cnt_q;
  logic [1:0]    ph;
  logic [6:0]    stp;
  logic [7:0]    rnd;
  logic [SW-1:0] elapsed;
  logic [6:0]    in_use;
  logic [SW-1:0] cur_dur;
  logic [SW-1:0] quo;
  logic [SW-1:0] eff_d;
  logic          div_done;
  logic [PW-1:0] prod;
  logic [TOTAL_W-1:0] acc;
  logic [TOTAL_W-1:0] acc_base;
  logic [TOTAL_W:0]   sum;
  logic [6:0]    widx;
  logic          pend;
  logic [1:0]    ev;
  logic          rej;
  logic [SW-1:0] rd_secs;
  logic [7:0]    rd_rnds;
  logic          rd_open;
  logic [8:0]    eff_r;
  logic [8:0]    mult;
  logic          more_rounds;
  logic [AW-1:0] rd_addr;
  logic          active;
  logic [SW-1:0] el_inc;
  logic [SW-1:0] rem_now;

  assign {rd_open, rd_rnds, rd_secs} = rd_q;
  assign active = (ph == PH_RUN) || (ph == PH_WAIT);

  always_ff @(posedge clk) begin
    if (rst) speed <= 16'd1;
    else if (cfg_we) speed <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q <= mode; idx_q <= entry_index; secs_q <= SW'(entry_seconds);
      rnds_q <= entry_rounds; opn_q <= entry_open; cnt_q <= step_count;
    end
  end

  // read address: current step, or walk index
  assign rd_addr = cmd.rd_cur ? AW'(stp) : AW'(widx);

  always_ff @(posedge clk) begin
    if (cmd.apply && mode_q == MODE_LOAD && !active && 32'(idx_q) < MAX_STEPS)
      mem[AW'(idx_q)] <= {opn_q, rnds_q, secs_q};
    if (cmd.tbl_rd) rd_q <= mem[rd_addr];
  end

  mrts_div #(.NW(SW), .DW(16)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(rd_secs), .den(speed),
    .done(div_done), .quo(quo)
  );

  // effective duration of the entry just divided
  assign eff_d = (quo == '0) ? SW'(1) : quo;

  // round multiplier for current (remaining rounds) or later step (all rounds)
  assign eff_r       = (rd_rnds == 8'd0) ? 9'd1 : {1'b0, rd_rnds};
  assign more_rounds = !rd_open && (9'(rnd) + 9'd1 < eff_r);
  always_comb begin
    if (cmd.mul_cur) mult = more_rounds ? eff_r - 9'(rnd) - 9'd1 : 9'd0;
    else mult = rd_open ? 9'd0 : eff_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) prod <= PW'(eff_d) * PW'(mult);
  end

  assign el_inc   = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign rem_now  = (ph == PH_RUN && elapsed < cur_dur) ? cur_dur - elapsed : '0;
  assign acc_base = cmd.acc_init ? TOTAL_W'(rem_now) : acc;
  assign sum      = {1'b0, acc_base} + (TOTAL_W+1)'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE; stp <= '0; rnd <= '0; elapsed <= '0; in_use <= '0;
      ev <= EV_NONE; rej <= 1'b0; pend <= 1'b0; widx <= '0; acc <= '0;
      cur_dur <= SW'(1);
    end else begin
      if (cmd.dur_ld) cur_dur <= eff_d;
      if (cmd.apply) begin
        ev   <= EV_NONE;
        rej  <= 1'b0;
        pend <= 1'b0;
        case (mode_q)
          MODE_TICK: if (ph == PH_RUN) begin
            elapsed <= el_inc;
            if (el_inc >= cur_dur) begin ph <= PH_WAIT; ev <= EV_EXPIRED; end
          end
          MODE_START: begin
            if (active || cnt_q == 7'd0 || 32'(cnt_q) > MAX_STEPS) rej <= 1'b1;
            else begin
              in_use <= cnt_q; stp <= '0; rnd <= '0; elapsed <= '0;
              ev <= EV_STARTED; pend <= 1'b1;
            end
          end
          MODE_CONFIRM: if (ph == PH_WAIT) begin
            if (more_rounds) begin
              rnd <= rnd + 1'b1; elapsed <= '0; ev <= EV_STARTED; pend <= 1'b1;
            end else begin
              rnd <= '0; stp <= stp + 7'd1;
              if (stp + 7'd1 >= in_use) begin ph <= PH_DONE; ev <= EV_FINISH; end
              else begin elapsed <= '0; ev <= EV_STARTED; pend <= 1'b1; end
            end
          end
          MODE_ABORT: begin
            ph <= PH_IDLE; stp <= '0; rnd <= '0; elapsed <= '0;
          end
          default: ;
        endcase
      end
      // new round: open flag of the fresh current entry picks run or wait
      if (cmd.round_go && pend) begin
        ph   <= rd_open ? PH_WAIT : PH_RUN;
        pend <= 1'b0;
      end
      if (cmd.acc_clr) acc <= '0;
      if (cmd.acc_init || cmd.acc_add)
        acc <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (cmd.walk_init) widx <= stp + 7'd1;
      if (cmd.walk_inc) widx <= widx + 7'd1;
    end
  end

  assign sts.div_done   = div_done;
  assign sts.need_total = active;
  assign sts.walk_end   = (widx >= in_use) || (32'(widx) >= MAX_STEPS);

  assign phase              = ph;
  assign step_now           = stp;
  assign round_now          = rnd;
  assign event_code         = ev;
  assign rejected           = rej;
  assign remaining_seconds  = 24'(rem_now);
  assign remaining_valid    = (ph == PH_RUN);
  assign total_left_seconds = active ? acc : '0;
endmodule
`default_nettype wire

>>> rtl/multi_step_round_timer_sequencer.sv
// Top level of the timed step sequencer.
//   channel | dir | handshake         | content
//   s_axis  | in  | tvalid/tready     | one command item
//   m_axis  | out | tvalid/tready     | one status item per command
//   cfg     | in  | cfg_we            | speed_factor
// One item at a time. Each item runs two divides by the speed factor, one bit
// per cycle. When the item leaves the block running or waiting, a multiply for
// the current step and a divide and multiply per later step in use follow to
// sum the total left. rst is synchronous; the step table is not cleared. The
// result holds until taken; no new item is accepted meanwhile.
`default_nettype none
module multi_step_round_timer_sequencer import mrts_pkg::*; #(
  parameter int MAX_STEPS    = 64,
  parameter int SECONDS_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode[2:0] entry_index[8:3] entry_seconds[32:9] entry_rounds[40:33]
  // entry_open[41] step_count[48:42]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // phase[1:0] step_now[8:2] round_now[16:9] event_code[18:17] rejected[19]
  // remaining_seconds[43:20] remaining_valid[44] total_left_seconds[84:45]
  output logic [87:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);
  mrts_cmd_t cmd;
  mrts_sts_t sts;
  logic in_fire, out_fire;
  logic [1:0]  phase, event_code;
  logic [6:0]  step_now;
  logic [7:0]  round_now;
  logic        rejected, remaining_valid;
  logic [23:0] remaining_seconds;
  logic [39:0] total_left_seconds;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  mrts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire), .sts(sts),
    .cmd(cmd), .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
  );

  mrts_dp #(.MAX_STEPS(MAX_STEPS), .SECONDS_BITS(SECONDS_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .mode(s_axis_tdata[2:0]), .entry_index(s_axis_tdata[8:3]),
    .entry_seconds(s_axis_tdata[32:9]), .entry_rounds(s_axis_tdata[40:33]),
    .entry_open(s_axis_tdata[41]), .step_count(s_axis_tdata[48:42]),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .phase(phase), .step_now(step_now), .round_now(round_now),
    .event_code(event_code), .rejected(rejected),
    .remaining_seconds(remaining_seconds), .remaining_valid(remaining_valid),
    .total_left_seconds(total_left_seconds)
  );

  assign m_axis_tdata = {3'd0, total_left_seconds, remaining_valid, remaining_seconds,
                         rejected, event_code, round_now, step_now, phase};

  // ready and valid never both high: one item in flight
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready with pending result");
  // an accepted item leads to a busy block next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready) else $error("accepted while busy");
  // remaining time only while running
  a_rem: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !remaining_valid |-> remaining_seconds == 24'd0)
    else $error("remaining outside run");
endmodule
`default_nettype wire
